// File: hdl/f64nrp_pkg.sv
package f64nrp_pkg;

  localparam int unsigned FracWidth    = 52;
  localparam int unsigned ExpInWidth   = 14;
  localparam int unsigned ExpOutWidth  = 11;
  localparam int unsigned FracLsb      = 10;
  localparam logic [63:0] ROUND_ADD    = 64'd512;
  localparam logic signed [13:0] UNDER_LIMIT = -14'sd53;
  localparam logic signed [14:0] EXP_INF     = 15'sd2047;

  typedef struct packed {
    logic signed [ExpInWidth-1:0] exponent_in;
    logic [63:0]                  fraction_in;
    logic                         sign_in;
  } in_t;

  typedef struct packed {
    logic                   sign_out;
    logic [ExpOutWidth-1:0] exponent_out;
    logic [FracWidth-1:0]   fraction_out;
  } out_t;

  // Normalised and aligned operand handed to the rounding stage.
  typedef struct packed {
    logic                         sign;
    logic                         denorm;
    logic                         flush;
    logic signed [ExpInWidth-1:0] exponent;
    logic [63:0]                  fraction;
  } norm_t;

endpackage

// File: hdl/f64nrp_norm.sv
module f64nrp_norm (
  input  f64nrp_pkg::in_t   in_word,
  output f64nrp_pkg::norm_t norm
);

  logic [6:0]         lz;
  logic [6:0]         shamt;
  logic               e_pos;
  logic signed [13:0] e1;
  logic signed [13:0] e_neg;
  logic [63:0]        f1;
  logic [5:0]         rsh;
  logic               denorm;
  logic               flush;

  // Leading zero count: the last set bit seen from the bottom wins.
  always_comb begin
    lz = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (in_word.fraction_in[i]) begin
        lz = 7'(63 - i);
      end
    end
  end

  assign e_pos = (in_word.exponent_in > 14'sd0) && (in_word.fraction_in != 64'd0);

  // The left shift is limited by the exponent so that it never goes below zero.
  always_comb begin
    if (!e_pos) begin
      shamt = 7'd0;
    end else if (in_word.exponent_in > $signed({7'd0, lz})) begin
      shamt = lz;
    end else begin
      shamt = in_word.exponent_in[6:0];
    end
  end

  assign e1     = in_word.exponent_in - $signed({7'd0, shamt});
  assign f1     = in_word.fraction_in << shamt;
  assign denorm = (e1 < 14'sd0) || ((e1 == 14'sd0) && !f1[63]);
  assign flush  = e1 < f64nrp_pkg::UNDER_LIMIT;
  assign e_neg  = -e1;
  assign rsh    = ((e1 < 14'sd0) && !flush) ? e_neg[5:0] : 6'd0;

  assign norm.sign     = in_word.sign_in;
  assign norm.denorm   = denorm;
  assign norm.flush    = flush;
  assign norm.exponent = denorm ? 14'sd0 : e1;
  assign norm.fraction = f1 >> rsh;

endmodule

// File: hdl/f64nrp_round.sv
module f64nrp_round (
  input  f64nrp_pkg::norm_t norm,
  output f64nrp_pkg::out_t  result
);

  logic [63:0]        f2;
  logic [63:0]        fsh;
  logic               top;
  logic signed [14:0] e3;

  // The rounding add wraps at 64 bits; a wrapped value gives no carry-out.
  assign f2  = norm.fraction + f64nrp_pkg::ROUND_ADD;
  assign top = f2[63];
  assign fsh = top ? (f2 >> 1) : f2;
  assign e3  = 15'(norm.exponent) + 15'sd1 + $signed({14'd0, top});

  always_comb begin
    result.sign_out = norm.sign;
    if (norm.flush) begin
      result.exponent_out = '0;
      result.fraction_out = '0;
    end else if (norm.denorm && !top) begin
      result.exponent_out = '0;
      result.fraction_out = f2[f64nrp_pkg::FracLsb +: f64nrp_pkg::FracWidth];
    end else if (e3 >= f64nrp_pkg::EXP_INF) begin
      result.exponent_out = '1;
      result.fraction_out = '0;
    end else begin
      result.exponent_out = e3[10:0];
      result.fraction_out = fsh[f64nrp_pkg::FracLsb +: f64nrp_pkg::FracWidth];
    end
  end

endmodule

// File: hdl/float64_normalize_round_pack_core.sv
// Channel | Direction | Handshake          | Word
// in      | input     | in_valid/in_stall   | f64nrp_pkg::in_t
// out     | output    | out_valid/out_stall | f64nrp_pkg::out_t
//
// The path is an input register, then one pass of normalise, align, round and
// pack into the result register. One word is taken every cycle while in_stall is low.
// Reset (rst, synchronous) empties both register stages.
// A stall on the output holds the result; the input stalls only when both
// stages are full and the output is stalled.
module float64_normalize_round_pack_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  f64nrp_pkg::in_t  in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output f64nrp_pkg::out_t out_word
);

  logic               s1_valid;
  f64nrp_pkg::in_t    s1_word;
  f64nrp_pkg::norm_t  norm;
  f64nrp_pkg::out_t   result;
  logic               s2_load;

  assign s2_load  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_word <= in_word;
    end
  end

  f64nrp_norm u_norm (
    .in_word (s1_word),
    .norm    (norm)
  );

  f64nrp_round u_round (
    .norm   (norm),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
    if (s2_load && s1_valid) begin
      out_word <= result;
    end
  end

  a_inf_zero_frac: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_word.exponent_out == 11'd2047)) |-> (out_word.fraction_out == '0))
    else $error("infinity with non-zero fraction");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_stall && out_valid && s1_valid))
    else $error("input stalled without a full pipeline");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_load) |=> out_valid)
    else $error("word lost between stages");

endmodule
